@@ hdl/facc_pkg.sv @@
// Package for the 128-bit fixed-point lane accumulator.
// Holds the request and result structs, the operation codes and default sizes.
// No dependencies.
`timescale 1ns / 1ps

package facc_pkg;

    localparam int DEFAULT_LANE_COUNT    = 4;
    localparam int DEFAULT_FRACTION_BITS = 38;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_SET  = 2'd1,
        KIND_ADD  = 2'd2,
        KIND_SUB  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [1:0]         lane;
        logic signed [63:0] operand_high;
        logic [63:0]        operand_low;
        logic [63:0]        real_value;
    } in_req_t;

    typedef struct packed {
        logic signed [63:0] lane_high;
        logic [63:0]        lane_low;
        logic [63:0]        lane_real;
    } out_res_t;

endpackage

@@ hdl/fixed_point_128_lane_accumulator_unit.sv @@
// Top level of the 128-bit fixed-point lane accumulator.
// Uses facc_pkg, facc_d2f and facc_f2d.
//
//  Channel | Ports                      | Payload   | Direction
//  request | s_valid, s_ready, s_data   | in_req_t  | in
//  result  | m_valid, m_ready, m_data   | out_res_t | out
//
// One request per cycle while results are taken; each result passes, after its request
// is taken: input register, lane update, double conversion into the output register.
// Lanes are written as a request leaves the input register, so the next request
// already sees the new value. Reset clears all lanes and empties the pipeline.
// A stalled result holds only the stages behind it that are full.
`timescale 1ns / 1ps

module fixed_point_128_lane_accumulator_unit
    import facc_pkg::*;
#(
    parameter int LANE_COUNT    = DEFAULT_LANE_COUNT,
    parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_req_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output out_res_t m_data
);

    localparam int IDX_W = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;

    logic [63:0]  lane_high_reg [LANE_COUNT];
    logic [63:0]  lane_low_reg  [LANE_COUNT];

    logic         v0_reg, v0_next;
    logic         v1_reg, v1_next;
    logic         v2_reg, v2_next;
    in_req_t      req_reg;
    logic [127:0] value_reg;
    out_res_t     res_reg;

    logic         rdy1, rdy2;
    logic         load1, load2;
    logic [IDX_W-1:0] idx;
    logic         in_range;
    logic [127:0] cur_value;
    logic [127:0] operand;
    logic [127:0] set_value;
    logic [127:0] new_value;
    logic [63:0]  real_bits;

    facc_d2f #(.FRACTION_BITS(FRACTION_BITS)) u_d2f (
        .real_bits  (req_reg.real_value),
        .fixed_value(set_value)
    );

    facc_f2d #(.FRACTION_BITS(FRACTION_BITS)) u_f2d (
        .fixed_value(value_reg),
        .real_bits  (real_bits)
    );

    always_comb begin
        rdy2    = !v2_reg || m_ready;
        rdy1    = !v1_reg || rdy2;
        s_ready = !v0_reg || rdy1;
        load1   = v0_reg && rdy1;
        load2   = v1_reg && rdy2;
        v0_next = s_ready ? s_valid : v0_reg;
        v1_next = rdy1 ? v0_reg : v1_reg;
        v2_next = rdy2 ? v1_reg : v2_reg;
        m_valid = v2_reg;
        m_data  = res_reg;
    end

    always_comb begin
        idx       = IDX_W'(req_reg.lane);
        in_range  = int'(req_reg.lane) < LANE_COUNT;
        cur_value = {lane_high_reg[idx], lane_low_reg[idx]};
        operand   = {req_reg.operand_high, req_reg.operand_low};
        case (req_reg.kind)
            KIND_LOAD: new_value = operand;
            KIND_SET:  new_value = set_value;
            KIND_ADD:  new_value = cur_value + operand;
            KIND_SUB:  new_value = cur_value - operand;
            default:   new_value = operand;
        endcase
        if (!in_range) begin
            new_value = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            for (int i = 0; i < LANE_COUNT; i++) begin
                lane_high_reg[i] <= '0;
                lane_low_reg[i]  <= '0;
            end
        end else begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            if (load1 && in_range) begin
                lane_high_reg[idx] <= new_value[127:64];
                lane_low_reg[idx]  <= new_value[63:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            req_reg <= s_data;
        end
        if (load1) begin
            value_reg <= new_value;
        end
        if (load2) begin
            res_reg.lane_high <= value_reg[127:64];
            res_reg.lane_low  <= value_reg[63:0];
            res_reg.lane_real <= real_bits;
        end
    end

endmodule

@@ hdl/facc_d2f.sv @@
// Converts an IEEE double to a signed 128-bit fixed-point value.
// Rounds to nearest even, saturates the magnitude at 2^104-1, maps NaN to zero.
// Depends on facc_pkg.
`timescale 1ns / 1ps

module facc_d2f
    import facc_pkg::*;
#(
    parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
    input  logic [63:0]  real_bits,
    output logic [127:0] fixed_value
);

    localparam logic [127:0] SAT_MAG = {24'd0, {104{1'b1}}};

    logic [10:0]        expo;
    logic [51:0]        frac;
    logic               negative;
    logic [52:0]        sig;
    logic signed [13:0] shift;
    logic [13:0]        rshift;
    logic [156:0]       wide;
    logic [106:0]       ext;
    logic [53:0]        q;
    logic               inc;
    logic [127:0]       mag;

    always_comb begin
        expo     = real_bits[62:52];
        frac     = real_bits[51:0];
        negative = real_bits[63];
        sig      = {(expo != 11'd0), frac};
        shift    = ((expo == 11'd0) ? 14'sd1 : $signed({3'b000, expo}))
                   - 14'sd1075 + $signed(14'(FRACTION_BITS));
        rshift   = 14'(-shift);
        wide     = 157'(sig) << shift[6:0];
        ext      = {sig, 54'd0} >> rshift[6:0];
        inc      = ext[53] & ((|ext[52:0]) | ext[54]);
        q        = {1'b0, ext[106:54]} + 54'(inc);
        mag      = '0;
        if (expo == 11'h7FF) begin
            mag = SAT_MAG;
        end else if (sig != 53'd0) begin
            if (shift >= 14'sd0) begin
                if (shift > 14'sd104 || (|wide[156:104])) begin
                    mag = SAT_MAG;
                end else begin
                    mag = wide[127:0];
                end
            end else if (rshift <= 14'd107) begin
                mag = 128'(q);
            end
        end
        if (expo == 11'h7FF && frac != 52'd0) begin
            fixed_value = '0;
        end else if (negative) begin
            fixed_value = ~mag + 128'd1;
        end else begin
            fixed_value = mag;
        end
    end

endmodule

@@ hdl/facc_f2d.sv @@
// Converts a signed 128-bit fixed-point value to an IEEE double.
// Normalizes the magnitude and rounds to nearest even.
// Depends on facc_pkg.
`timescale 1ns / 1ps

module facc_f2d
    import facc_pkg::*;
#(
    parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
    input  logic [127:0] fixed_value,
    output logic [63:0]  real_bits
);

    logic         sign;
    logic [127:0] mag;
    logic [127:0] norm;
    logic [6:0]   lz;
    logic [7:0]   len;
    logic         inc;
    logic [53:0]  q;
    logic         ovf;
    logic [11:0]  expo;
    logic [51:0]  mant;

    always_comb begin
        sign = fixed_value[127];
        mag  = sign ? (~fixed_value + 128'd1) : fixed_value;
        norm = mag;
        lz   = '0;
        // Leading-zero count by halving steps; norm ends with its top bit set unless the value is zero.
        if (norm[127:64] == '0) begin norm = norm << 64; lz = lz + 7'd64; end
        if (norm[127:96] == '0) begin norm = norm << 32; lz = lz + 7'd32; end
        if (norm[127:112] == '0) begin norm = norm << 16; lz = lz + 7'd16; end
        if (norm[127:120] == '0) begin norm = norm << 8; lz = lz + 7'd8; end
        if (norm[127:124] == '0) begin norm = norm << 4; lz = lz + 7'd4; end
        if (norm[127:126] == '0) begin norm = norm << 2; lz = lz + 7'd2; end
        if (norm[127] == 1'b0) begin norm = norm << 1; lz = lz + 7'd1; end
        len  = 8'd128 - 8'(lz);
        inc  = norm[74] & ((|norm[73:0]) | norm[75]);
        q    = {1'b0, norm[127:75]} + 54'(inc);
        ovf  = q[53];
        expo = 12'(len) + 12'(ovf) + 12'd1022 - 12'(FRACTION_BITS);
        mant = ovf ? 52'd0 : q[51:0];
        if (mag == 128'd0) begin
            real_bits = '0;
        end else begin
            real_bits = {sign, expo[10:0], mant};
        end
    end

endmodule

@@ hdl/facc_checker.sv @@
// Port-level checks for the 128-bit fixed-point lane accumulator.
// Bound to fixed_point_128_lane_accumulator_unit; depends on facc_pkg.
`timescale 1ns / 1ps

module facc_port_checks
    import facc_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input in_req_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input out_res_t m_data
);

    // A result is not shown in the cycle right after reset.
    a_empty_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // The double carries the sign of the lane value.
    a_real_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.lane_real[63] == m_data.lane_high[63])
        else $error("double sign mismatch");

    a_zero_real: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.lane_high == 64'sd0 && m_data.lane_low == 64'd0
        |-> m_data.lane_real == 64'd0)
        else $error("zero lane not reported as +0.0");

endmodule

bind fixed_point_128_lane_accumulator_unit facc_port_checks u_facc_port_checks (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .s_data (s_data),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);
